/* hdl/box_vertex_sampler_defines.svh */
// assertion macros for the box vertex sampler checker
// no dependencies; taken in by the checker through `include
`ifndef BOX_VERTEX_SAMPLER_DEFINES_SVH
`define BOX_VERTEX_SAMPLER_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define BVS_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define BVS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/bvs_pkg.sv */
// shared constants, codes and types of the box vertex sampler
// no dependencies; compiled before every other file
package bvs_pkg;

  localparam int unsigned OUT_BITS     = 26;
  localparam int unsigned NUM_STAGES   = 6;
  localparam int unsigned CFG_IDX_BITS = 3;

  // sample mode codes
  localparam logic [1:0] MODE_VOLUME = 2'd1;
  localparam logic [1:0] MODE_FACES  = 2'd2;

  localparam logic [5:0] FACE_MASK_RESET = 6'h3f;

  // configuration register indexes
  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_SAMPLE_MODE = 3'd0,
    REG_FACE_MASK   = 3'd1,
    REG_SIZE_X      = 3'd2,
    REG_SIZE_Y      = 3'd3,
    REG_SIZE_Z      = 3'd4,
    REG_SKIN_OFFSET = 3'd5,
    REG_SKIN_DEPTH  = 3'd6
  } bvs_reg_e;

  // box faces, in mask bit order
  typedef enum logic [2:0] {
    FACE_XN = 3'd0,
    FACE_XP = 3'd1,
    FACE_YN = 3'd2,
    FACE_YP = 3'd3,
    FACE_ZN = 3'd4,
    FACE_ZP = 3'd5
  } bvs_face_e;

  // per-stage load enables and valid bits, stage 1 at bit 0
  typedef struct packed {
    logic [NUM_STAGES-1:0] load;
    logic [NUM_STAGES-1:0] valid;
  } bvs_pipe_t;

endpackage

/* hdl/bvs_cfg_if.sv */
// configuration write channel: register index and write data
// depends on bvs_pkg
interface bvs_cfg_if #(
  parameter int unsigned LENGTH_BITS = 24
);
  import bvs_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [CFG_IDX_BITS-1:0] index;
  logic [LENGTH_BITS-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* hdl/bvs_in_if.sv */
// input channel: four uniform fractions per word
// no dependencies
interface bvs_in_if #(
  parameter int unsigned FRACTION_BITS = 16
);
  logic                     valid;
  logic                     ready;
  logic [FRACTION_BITS-1:0] face_pick;
  logic [FRACTION_BITS-1:0] coord_a;
  logic [FRACTION_BITS-1:0] coord_b;
  logic [FRACTION_BITS-1:0] depth_jitter;

  modport source (output valid, output face_pick, output coord_a, output coord_b,
                  output depth_jitter, input ready);
  modport sink   (input valid, input face_pick, input coord_a, input coord_b,
                  input depth_jitter, output ready);
endinterface

/* hdl/bvs_out_if.sv */
// output channel: sampled position and setup error flag
// depends on bvs_pkg
interface bvs_out_if;
  import bvs_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [OUT_BITS-1:0] pos_x;
  logic signed [OUT_BITS-1:0] pos_y;
  logic signed [OUT_BITS-1:0] pos_z;
  logic                       bad_setup;

  modport source (output valid, output pos_x, output pos_y, output pos_z,
                  output bad_setup, input ready);
  modport sink   (input valid, input pos_x, input pos_y, input pos_z,
                  input bad_setup, output ready);
endinterface

/* hdl/bvs_pipe_ctrl.sv */
// valid bits and load enables of the sampler pipeline
// depends on bvs_pkg
module bvs_pipe_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              out_ready_i,
  output bvs_pkg::bvs_pipe_t pipe_o
);
  import bvs_pkg::*;

  logic [NUM_STAGES-1:0] valid_q;
  logic [NUM_STAGES-1:0] valid_d;
  logic [NUM_STAGES-1:0] load;

  // a stage loads when it is empty or its successor moves on
  always_comb begin
    load[NUM_STAGES-1] = !valid_q[NUM_STAGES-1] || out_ready_i;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      load[k] = !valid_q[k] || load[k+1];
    end
  end

  // valid bits shift along with the data
  assign valid_d = (load & {valid_q[NUM_STAGES-2:0], in_valid_i}) | (~load & valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign pipe_o.load  = load;
  assign pipe_o.valid = valid_q;

endmodule

/* hdl/bvs_face_pick.sv */
// area-weighted face choice: pick * total against running area sums
// stages 3 to 5 of the pipeline; depends on bvs_pkg
module bvs_face_pick #(
  parameter int unsigned FRACTION_BITS = 16,
  parameter int unsigned LENGTH_BITS   = 24
) (
  input  logic                            clk_i,
  input  bvs_pkg::bvs_pipe_t              pipe_i,
  input  logic [FRACTION_BITS-1:0]        pick_i,
  input  logic [2*LENGTH_BITS+2:0]        total_i,
  input  logic [4:0][2*LENGTH_BITS+2:0]   cum_i,
  output bvs_pkg::bvs_face_e              face_o
);
  import bvs_pkg::*;

  localparam int unsigned FB  = FRACTION_BITS;
  localparam int unsigned TW  = 2 * LENGTH_BITS + 3;
  localparam int unsigned TLO = (TW + 1) / 2;
  localparam int unsigned THI = TW - TLO;
  localparam int unsigned PRW = FB + TW;

  logic [FB+TLO-1:0]   plo_q;
  logic [FB+THI-1:0]   phi_q;
  logic [4:0][TW-1:0]  cum3_q;
  logic [PRW-1:0]      prod_d;
  logic [PRW-1:0]      prod_q;
  logic [4:0][TW-1:0]  cum4_q;
  logic [4:0]          below;
  bvs_face_e           face_d;
  bvs_face_e           face_q;

  // stage 3: pick times total, split in two partial products
  always_ff @(posedge clk_i) begin
    if (pipe_i.load[2]) begin
      plo_q  <= (FB+TLO)'(pick_i) * (FB+TLO)'(total_i[TLO-1:0]);
      phi_q  <= (FB+THI)'(pick_i) * (FB+THI)'(total_i[TW-1:TLO]);
      cum3_q <= cum_i;
    end
  end

  // stage 4: combine partial products
  assign prod_d = PRW'(plo_q) + (PRW'(phi_q) << TLO);

  always_ff @(posedge clk_i) begin
    if (pipe_i.load[3]) begin
      prod_q <= prod_d;
      cum4_q <= cum3_q;
    end
  end

  // stage 5: first running sum above the scaled pick wins, else +z
  always_comb begin
    face_d = FACE_ZP;
    for (int k = 4; k >= 0; k--) begin
      below[k] = prod_q < {cum4_q[k], {FB{1'b0}}};
      if (below[k]) begin
        face_d = bvs_face_e'(3'(k));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_i.load[4]) begin
      face_q <= face_d;
    end
  end

  assign face_o = face_q;

endmodule

/* hdl/box_vertex_sampler.sv */
// box vertex sampler top level: config registers, datapath stages, output register
// depends on bvs_pkg, bvs_*_if, bvs_pipe_ctrl, bvs_face_pick
//
// channel   direction  handshake       payload
// cfg_i     in         valid / ready   index, data (ready always high)
// in_i      in         valid / ready   face_pick, coord_a, coord_b, depth_jitter
// out_o     out        valid / ready   pos_x, pos_y, pos_z, bad_setup
//
// one word per cycle enters and leaves while the output is not stalled; the
// six register stages are multiply, sums and rounding, two-part product of the
// face pick, product combine, face compare, face select and saturation
// each stage has a valid bit and loads when empty or when its successor moves,
// so bubbles are absorbed and a stalled output holds while earlier stages fill
// reset clears the valid bits and sets config to mode 0, mask 63, lengths 0
module box_vertex_sampler #(
  parameter int unsigned FRACTION_BITS = 16,
  parameter int unsigned LENGTH_BITS   = 24
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  bvs_cfg_if.sink   cfg_i,
  bvs_in_if.sink    in_i,
  bvs_out_if.source out_o
);
  import bvs_pkg::*;

  localparam int unsigned FB = FRACTION_BITS;
  localparam int unsigned LB = LENGTH_BITS;
  localparam int unsigned PW = FB + LB + 2;
  localparam int unsigned NW = FB + LB + 3;
  localparam int unsigned AW = 2 * LB;
  localparam int unsigned TW = 2 * LB + 3;
  localparam int unsigned RW = LB + 3;
  localparam int unsigned SW = ((RW > OUT_BITS) ? RW : OUT_BITS) + 1;

  localparam logic signed [PW-1:0] C_HALF = PW'(1) <<< FB;
  localparam logic signed [NW-1:0] N_HALF = NW'(1) <<< FB;
  localparam logic signed [SW-1:0] SAT_HI = (SW'(1) <<< (OUT_BITS - 1)) - SW'(1);
  localparam logic signed [SW-1:0] SAT_LO = -SAT_HI - SW'(1);

  typedef struct packed {
    logic signed [LB:0]   c_a;
    logic signed [LB:0]   c_b;
    logic signed [LB:0]   c_c;
    logic signed [LB:0]   c_d;
    logic signed [LB+1:0] t_x;
    logic signed [LB+1:0] t_y;
    logic signed [LB+1:0] t_z;
    logic                 bulk;
    logic                 bad;
  } lane_t;

  function automatic logic signed [OUT_BITS-1:0] sat_out(input logic signed [RW-1:0] v);
    logic signed [SW-1:0] w;
    w = SW'(v);
    if (w > SAT_HI) begin
      w = SAT_HI;
    end else if (w < SAT_LO) begin
      w = SAT_LO;
    end
    return OUT_BITS'(w);
  endfunction

  // configuration registers
  logic [1:0]           sample_mode_q;
  logic [5:0]           face_mask_q;
  logic [LB-1:0]        size_x_q;
  logic [LB-1:0]        size_y_q;
  logic [LB-1:0]        size_z_q;
  logic signed [LB-1:0] skin_offset_q;
  logic [LB-1:0]        skin_depth_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_mode_q <= '0;
      face_mask_q   <= FACE_MASK_RESET;
      size_x_q      <= '0;
      size_y_q      <= '0;
      size_z_q      <= '0;
      skin_offset_q <= '0;
      skin_depth_q  <= '0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        REG_SAMPLE_MODE: sample_mode_q <= cfg_i.data[1:0];
        REG_FACE_MASK:   face_mask_q   <= cfg_i.data[5:0];
        REG_SIZE_X:      size_x_q      <= cfg_i.data;
        REG_SIZE_Y:      size_y_q      <= cfg_i.data;
        REG_SIZE_Z:      size_z_q      <= cfg_i.data;
        REG_SKIN_OFFSET: skin_offset_q <= signed'(cfg_i.data);
        REG_SKIN_DEPTH:  skin_depth_q  <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // pipeline control
  bvs_pipe_t pipe;

  bvs_pipe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .out_ready_i (out_o.ready),
    .pipe_o      (pipe)
  );

  assign in_i.ready  = pipe.load[0];
  assign out_o.valid = pipe.valid[NUM_STAGES-1];

  // stage 1: centered fractions times lengths, face areas
  logic signed [FB:0] dev_0, dev_1, dev_2, dev_3;
  logic signed [FB:0] dev_a;
  logic signed [LB:0] len_a, len_b, len_c, len_d, len_j;
  logic               bulk_d, bad_d;

  logic signed [PW-1:0] prod_a_q, prod_b_q, prod_c_q, prod_d_q, prod_j_q;
  logic [AW-1:0]        area_x_q, area_y_q, area_z_q;
  logic [FB-1:0]        pick1_q;
  logic                 bulk1_q, bad1_q;

  // 2f - 2^FB by flipping the top bit of 2f
  assign dev_0 = {~in_i.face_pick[FB-1], in_i.face_pick[FB-2:0], 1'b0};
  assign dev_1 = {~in_i.coord_a[FB-1], in_i.coord_a[FB-2:0], 1'b0};
  assign dev_2 = {~in_i.coord_b[FB-1], in_i.coord_b[FB-2:0], 1'b0};
  assign dev_3 = {~in_i.depth_jitter[FB-1], in_i.depth_jitter[FB-2:0], 1'b0};

  assign bulk_d = (sample_mode_q == MODE_VOLUME);
  assign bad_d  = !bulk_d && !((sample_mode_q == MODE_FACES) && (face_mask_q != '0));

  // bulk shrinks each side by the skin; surface uses the plain sides
  always_comb begin
    dev_a = bulk_d ? dev_0 : dev_1;
    if (bulk_d) begin
      len_a = signed'({1'b0, size_x_q}) - signed'({1'b0, skin_depth_q});
      len_b = signed'({1'b0, size_y_q}) - signed'({1'b0, skin_depth_q});
      len_c = signed'({1'b0, size_z_q}) - signed'({1'b0, skin_depth_q});
    end else begin
      len_a = signed'({1'b0, size_x_q});
      len_b = signed'({1'b0, size_y_q});
      len_c = signed'({1'b0, size_z_q});
    end
    len_d = signed'({1'b0, size_y_q});
    len_j = signed'({1'b0, skin_depth_q});
  end

  always_ff @(posedge clk_i) begin
    if (pipe.load[0]) begin
      prod_a_q <= PW'(dev_a) * PW'(len_a);
      prod_b_q <= PW'(dev_1) * PW'(len_b);
      prod_c_q <= PW'(dev_2) * PW'(len_c);
      prod_d_q <= PW'(dev_2) * PW'(len_d);
      prod_j_q <= PW'(dev_3) * PW'(len_j);
      area_x_q <= AW'(size_y_q) * AW'(size_z_q);
      area_y_q <= AW'(size_x_q) * AW'(size_z_q);
      area_z_q <= AW'(size_x_q) * AW'(size_y_q);
      pick1_q  <= in_i.face_pick;
      bulk1_q  <= bulk_d;
      bad1_q   <= bad_d;
    end
  end

  // stage 2: masked running area sums, rounding of in-face and outward terms
  logic [TW-1:0]        ext_x0, ext_xp, ext_y0, ext_yp, ext_z0, ext_zp;
  logic [5:0][TW-1:0]   cum_d;
  logic signed [PW-1:0] sum_a, sum_b, sum_c, sum_d;
  logic signed [NW-1:0] out_base, out_x, out_y, out_z;
  lane_t                lane2_d;

  logic [5:0][TW-1:0]   cum2_q;
  logic [FB-1:0]        pick2_q;
  lane_t                lane2_q, lane3_q, lane4_q, lane5_q;

  // each pair of faces adds zero, one or two areas
  always_comb begin
    ext_x0 = face_mask_q[0] ? TW'(area_x_q) : '0;
    ext_y0 = face_mask_q[2] ? TW'(area_y_q) : '0;
    ext_z0 = face_mask_q[4] ? TW'(area_z_q) : '0;
    ext_xp = (face_mask_q[0] && face_mask_q[1]) ? (TW'(area_x_q) << 1) :
             (face_mask_q[0] || face_mask_q[1]) ? TW'(area_x_q) : '0;
    ext_yp = (face_mask_q[2] && face_mask_q[3]) ? (TW'(area_y_q) << 1) :
             (face_mask_q[2] || face_mask_q[3]) ? TW'(area_y_q) : '0;
    ext_zp = (face_mask_q[4] && face_mask_q[5]) ? (TW'(area_z_q) << 1) :
             (face_mask_q[4] || face_mask_q[5]) ? TW'(area_z_q) : '0;
    cum_d[0] = ext_x0;
    cum_d[1] = ext_xp;
    cum_d[2] = ext_xp + ext_y0;
    cum_d[3] = ext_xp + ext_yp;
    cum_d[4] = ext_xp + ext_yp + ext_z0;
    cum_d[5] = ext_xp + ext_yp + ext_zp;
  end

  // round half up: add half an lsb, then arithmetic shift
  always_comb begin
    sum_a    = prod_a_q + C_HALF;
    sum_b    = prod_b_q + C_HALF;
    sum_c    = prod_c_q + C_HALF;
    sum_d    = prod_d_q + C_HALF;
    out_base = (NW'(skin_offset_q) <<< (FB + 1)) + NW'(prod_j_q) + N_HALF;
    out_x    = out_base + (NW'({1'b0, size_x_q}) << FB);
    out_y    = out_base + (NW'({1'b0, size_y_q}) << FB);
    out_z    = out_base + (NW'({1'b0, size_z_q}) << FB);
    lane2_d.c_a  = (LB+1)'(sum_a >>> (FB + 1));
    lane2_d.c_b  = (LB+1)'(sum_b >>> (FB + 1));
    lane2_d.c_c  = (LB+1)'(sum_c >>> (FB + 1));
    lane2_d.c_d  = (LB+1)'(sum_d >>> (FB + 1));
    lane2_d.t_x  = (LB+2)'(out_x >>> (FB + 1));
    lane2_d.t_y  = (LB+2)'(out_y >>> (FB + 1));
    lane2_d.t_z  = (LB+2)'(out_z >>> (FB + 1));
    lane2_d.bulk = bulk1_q;
    lane2_d.bad  = bad1_q;
  end

  always_ff @(posedge clk_i) begin
    if (pipe.load[1]) begin
      cum2_q  <= cum_d;
      pick2_q <= pick1_q;
      lane2_q <= lane2_d;
    end
  end

  // stages 3 to 5: face choice, coordinates ride alongside
  bvs_face_e face5;

  bvs_face_pick #(
    .FRACTION_BITS (FRACTION_BITS),
    .LENGTH_BITS   (LENGTH_BITS)
  ) u_face_pick (
    .clk_i   (clk_i),
    .pipe_i  (pipe),
    .pick_i  (pick2_q),
    .total_i (cum2_q[5]),
    .cum_i   (cum2_q[4:0]),
    .face_o  (face5)
  );

  always_ff @(posedge clk_i) begin
    if (pipe.load[2]) begin
      lane3_q <= lane2_q;
    end
    if (pipe.load[3]) begin
      lane4_q <= lane3_q;
    end
    if (pipe.load[4]) begin
      lane5_q <= lane4_q;
    end
  end

  // stage 6: place on the chosen face, negate on minus faces, saturate
  logic signed [RW-1:0]       wx, wy, wz;
  logic signed [RW-1:0]       tx_ext, ty_ext, tz_ext;
  logic signed [OUT_BITS-1:0] pos_x_q, pos_y_q, pos_z_q;
  logic                       bad_q;

  always_comb begin
    tx_ext = RW'(lane5_q.t_x);
    ty_ext = RW'(lane5_q.t_y);
    tz_ext = RW'(lane5_q.t_z);
    wx = '0;
    wy = '0;
    wz = '0;
    if (lane5_q.bad) begin
      wx = '0;
    end else if (lane5_q.bulk) begin
      wx = RW'(lane5_q.c_a);
      wy = RW'(lane5_q.c_b);
      wz = RW'(lane5_q.c_c);
    end else begin
      case (face5) inside
        FACE_XN, FACE_XP: begin
          wx = (face5 == FACE_XN) ? -tx_ext : tx_ext;
          wy = RW'(lane5_q.c_b);
          wz = RW'(lane5_q.c_c);
        end
        FACE_YN, FACE_YP: begin
          wx = RW'(lane5_q.c_a);
          wy = (face5 == FACE_YN) ? -ty_ext : ty_ext;
          wz = RW'(lane5_q.c_c);
        end
        default: begin
          wx = RW'(lane5_q.c_a);
          wy = RW'(lane5_q.c_d);
          wz = (face5 == FACE_ZN) ? -tz_ext : tz_ext;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe.load[5]) begin
      pos_x_q <= sat_out(wx);
      pos_y_q <= sat_out(wy);
      pos_z_q <= sat_out(wz);
      bad_q   <= lane5_q.bad;
    end
  end

  assign out_o.pos_x     = pos_x_q;
  assign out_o.pos_y     = pos_y_q;
  assign out_o.pos_z     = pos_z_q;
  assign out_o.bad_setup = bad_q;

endmodule

/* hdl/bvs_checker.sv */
// port-level checker of the box vertex sampler, bound to the top level
// depends on bvs_pkg and box_vertex_sampler_defines.svh
`include "box_vertex_sampler_defines.svh"

module bvs_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_ready_i,
  input logic                                out_valid_i,
  input logic                                out_ready_i,
  input logic signed [bvs_pkg::OUT_BITS-1:0] pos_x_i,
  input logic signed [bvs_pkg::OUT_BITS-1:0] pos_y_i,
  input logic signed [bvs_pkg::OUT_BITS-1:0] pos_z_i,
  input logic                                bad_setup_i
);
  import bvs_pkg::*;

  localparam int unsigned CW = $clog2(NUM_STAGES + 2);

  logic [CW-1:0] inflight_q;
  logic [CW-1:0] inflight_d;
  logic          in_acc;
  logic          out_acc;

  // words accepted but not yet delivered
  assign in_acc     = in_valid_i && in_ready_i;
  assign out_acc    = out_valid_i && out_ready_i;
  assign inflight_d = inflight_q + CW'(in_acc) - CW'(out_acc);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else begin
      inflight_q <= inflight_d;
    end
  end

  `BVS_ASSERT_NOW(a_room_when_out_empty, clk_i, rst_ni, !out_valid_i, in_ready_i, "input stalled with empty output")
  `BVS_ASSERT_NOW(a_out_has_source, clk_i, rst_ni, out_valid_i, inflight_q != '0, "result with no word in flight")
  `BVS_ASSERT_NOW(a_bad_gives_zero, clk_i, rst_ni, out_valid_i && bad_setup_i, (pos_x_i == '0) && (pos_y_i == '0) && (pos_z_i == '0), "bad setup with nonzero position")
  `BVS_ASSERT_NEXT(a_out_valid_holds, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i, "output valid dropped while stalled")
  `BVS_ASSERT_NEXT(a_out_data_holds, clk_i, rst_ni, out_valid_i && !out_ready_i, $stable(pos_x_i) && $stable(pos_y_i) && $stable(pos_z_i) && $stable(bad_setup_i), "output word changed while stalled")

endmodule

bind box_vertex_sampler bvs_checker u_bvs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .pos_x_i     (out_o.pos_x),
  .pos_y_i     (out_o.pos_y),
  .pos_z_i     (out_o.pos_z),
  .bad_setup_i (out_o.bad_setup)
);

/* bench/tb_box_vertex_sampler.sv */
`timescale 1ns / 1ps
// testbench of box_vertex_sampler: directed and random fraction words, each
// output word checked field by field against a built-in point predictor
// depends on bvs_pkg, bvs_cfg_if, bvs_in_if, bvs_out_if and the block itself
module tb_box_vertex_sampler;
  import bvs_pkg::*;

  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned LEN_BITS  = 24;
  localparam longint FRAC_ONE       = longint'(1) << FRAC_BITS;
  localparam int LATENCY            = 6;
  localparam int MAX_IDLE           = 14;
  localparam int HOLD_CYCLES        = 150;
  localparam int HOLD_PHASE         = 2;
  localparam int CYCLE_LIMIT        = 400000;
  localparam int RANDOM_PHASES      = 12;
  localparam int PHASE_WORDS        = 136;
  localparam int PRINT_LIMIT        = 60;

  // mode codes that the block rejects
  localparam logic [1:0] MODE_OFF   = 2'd0;
  localparam logic [1:0] MODE_SPARE = 2'd3;

  localparam logic [LEN_BITS-1:0]  LEN_MAX    = '1;
  localparam logic [LEN_BITS-1:0]  OFFSET_MAX = {1'b0, {(LEN_BITS-1){1'b1}}};
  localparam logic [LEN_BITS-1:0]  OFFSET_MIN = {1'b1, {(LEN_BITS-1){1'b0}}};
  localparam logic [FRAC_BITS-1:0] FRAC_MAX   = '1;
  localparam logic [FRAC_BITS-1:0] FRAC_HALF  = {1'b1, {(FRAC_BITS-1){1'b0}}};

  typedef struct packed {
    logic [FRAC_BITS-1:0] pick;
    logic [FRAC_BITS-1:0] coord_a;
    logic [FRAC_BITS-1:0] coord_b;
    logic [FRAC_BITS-1:0] jitter;
  } fraction_word_t;

  typedef struct packed {
    logic signed [OUT_BITS-1:0] x;
    logic signed [OUT_BITS-1:0] y;
    logic signed [OUT_BITS-1:0] z;
    logic                       bad;
  } point_t;

  logic clk_i;
  logic rst_ni;

  bvs_cfg_if #(.LENGTH_BITS(LEN_BITS)) cfg_ch ();
  bvs_in_if #(.FRACTION_BITS(FRAC_BITS)) in_ch ();
  bvs_out_if out_ch ();

  box_vertex_sampler #(
    .FRACTION_BITS(FRAC_BITS),
    .LENGTH_BITS  (LEN_BITS)
  ) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg_ch),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  // predictor copy of the box setup
  logic [1:0]                 box_mode;
  logic [5:0]                 box_mask;
  logic [LEN_BITS-1:0]        box_size_x;
  logic [LEN_BITS-1:0]        box_size_y;
  logic [LEN_BITS-1:0]        box_size_z;
  logic signed [LEN_BITS-1:0] box_offset;
  logic [LEN_BITS-1:0]        box_depth;

  fraction_word_t pending_words[$];
  point_t         expected_points[$];
  int             n_queued;
  int             n_taken;
  int             n_checked;
  int             n_errors;
  int             send_idle;
  int             recv_idle;
  bit             hold_go;
  logic           hold_rx;
  int             cycle_count;

  // clock
  initial clk_i = 1'b0;
  always begin
    #1 clk_i = ~clk_i;
  end

  // (f - 1/2) * len, rounded half up
  function automatic longint centered(logic [FRAC_BITS-1:0] f, longint len);
    longint d;
    d = 2 * longint'(f) - FRAC_ONE;
    return (d * len + FRAC_ONE) >>> (FRAC_BITS + 1);
  endfunction

  // side/2 + offset + (jit - 1/2) * depth, rounded half up
  function automatic longint outward(logic [LEN_BITS-1:0] side, logic [FRAC_BITS-1:0] jit);
    longint d;
    longint n;
    d = 2 * longint'(jit) - FRAC_ONE;
    n = longint'(side) * FRAC_ONE + longint'(box_offset) * 2 * FRAC_ONE
      + d * longint'(box_depth);
    return (n + FRAC_ONE) >>> (FRAC_BITS + 1);
  endfunction

  function automatic logic signed [OUT_BITS-1:0] clamp_out(longint v);
    longint top;
    top = (longint'(1) << (OUT_BITS - 1)) - 1;
    if (v > top) v = top;
    else if (v < -top - 1) v = -top - 1;
    return v[OUT_BITS-1:0];
  endfunction

  // pick * total < run * 2^FRAC_BITS, wide enough to be exact
  function automatic bit pick_below(logic [FRAC_BITS-1:0] f, logic [63:0] total,
                                    logic [63:0] run);
    logic [127:0] lhs;
    logic [127:0] rhs;
    lhs = 128'(f) * 128'(total);
    rhs = 128'(run) << FRAC_BITS;
    return lhs < rhs;
  endfunction

  // expected point for one fraction word under the current setup
  function automatic point_t predict_point(fraction_word_t w);
    point_t     pt;
    longint     px;
    longint     py;
    longint     pz;
    longint     reach;
    logic [63:0] area [6];
    logic [63:0] running [6];
    logic [63:0] total;
    bvs_face_e  face;
    bit         found;
    int         k;
    px = 0;
    py = 0;
    pz = 0;
    pt.bad = 1'b0;
    if (box_mode == MODE_VOLUME) begin
      px = centered(w.pick, longint'(box_size_x) - longint'(box_depth));
      py = centered(w.coord_a, longint'(box_size_y) - longint'(box_depth));
      pz = centered(w.coord_b, longint'(box_size_z) - longint'(box_depth));
    end else if (box_mode == MODE_FACES && box_mask != '0) begin
      area[0] = 64'(box_size_y) * 64'(box_size_z);
      area[1] = area[0];
      area[2] = 64'(box_size_x) * 64'(box_size_z);
      area[3] = area[2];
      area[4] = 64'(box_size_x) * 64'(box_size_y);
      area[5] = area[4];
      total = '0;
      for (k = 0; k < 6; k++) begin
        if (box_mask[k]) total += area[k];
        running[k] = total;
      end
      // first face whose running area exceeds the scaled pick, else top z
      face = FACE_ZP;
      found = 1'b0;
      for (k = 0; k < 5; k++) begin
        if (!found && pick_below(w.pick, total, running[k])) begin
          face = bvs_face_e'(k);
          found = 1'b1;
        end
      end
      case (face)
        FACE_XN, FACE_XP: begin
          reach = outward(box_size_x, w.jitter);
          py = centered(w.coord_a, longint'(box_size_y));
          pz = centered(w.coord_b, longint'(box_size_z));
          px = (face == FACE_XN) ? -reach : reach;
        end
        FACE_YN, FACE_YP: begin
          reach = outward(box_size_y, w.jitter);
          px = centered(w.coord_a, longint'(box_size_x));
          pz = centered(w.coord_b, longint'(box_size_z));
          py = (face == FACE_YN) ? -reach : reach;
        end
        default: begin
          reach = outward(box_size_z, w.jitter);
          px = centered(w.coord_a, longint'(box_size_x));
          py = centered(w.coord_b, longint'(box_size_y));
          pz = (face == FACE_ZN) ? -reach : reach;
        end
      endcase
    end else begin
      pt.bad = 1'b1;
    end
    pt.x = clamp_out(px);
    pt.y = clamp_out(py);
    pt.z = clamp_out(pz);
    return pt;
  endfunction

  function automatic int draw_idle(int level);
    case (level)
      0: return 0;
      1: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, MAX_IDLE) : 0;
      default: return $urandom_range(0, MAX_IDLE);
    endcase
  endfunction

  function automatic logic [FRAC_BITS-1:0] draw_fraction();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return FRAC_MAX;
      2: return FRAC_HALF;
      default: return FRAC_BITS'($urandom_range(0, FRAC_MAX));
    endcase
  endfunction

  function automatic logic [LEN_BITS-1:0] draw_length();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return LEN_MAX;
      2: return LEN_BITS'($urandom_range(1, 255));
      3: return LEN_BITS'($urandom_range(0, 4096));
      default: return LEN_BITS'($urandom);
    endcase
  endfunction

  function automatic void push_word(logic [FRAC_BITS-1:0] pick, logic [FRAC_BITS-1:0] ca,
                                    logic [FRAC_BITS-1:0] cb, logic [FRAC_BITS-1:0] jit);
    pending_words.push_back('{pick: pick, coord_a: ca, coord_b: cb, jitter: jit});
    n_queued++;
  endfunction

  task automatic report_mismatch(string msg);
    n_errors++;
    if (n_errors <= PRINT_LIMIT) $display("mismatch at word %0d: %s", n_checked, msg);
  endtask

  // one register write, mirrored into the predictor once accepted
  task automatic write_reg(bvs_reg_e idx, logic [LEN_BITS-1:0] val);
    @(posedge clk_i);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    case (idx)
      REG_SAMPLE_MODE: box_mode   = val[1:0];
      REG_FACE_MASK:   box_mask   = val[5:0];
      REG_SIZE_X:      box_size_x = val;
      REG_SIZE_Y:      box_size_y = val;
      REG_SIZE_Z:      box_size_z = val;
      REG_SKIN_OFFSET: box_offset = val;
      REG_SKIN_DEPTH:  box_depth  = val;
      default: ;
    endcase
    cfg_ch.valid <= 1'b0;
  endtask

  // wait until every queued word went in and every point came out
  task automatic drain();
    while (!(pending_words.size() == 0 && n_taken == n_queued &&
             expected_points.size() == 0))
      @(posedge clk_i);
    repeat (LATENCY + 2) @(posedge clk_i);
  endtask

  // input word driver, predicts each accepted word
  fraction_word_t tx_word;
  int             tx_gap;
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
      tx_gap = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        expected_points.push_back(predict_point(tx_word));
        n_taken++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_ch.valid <= 1'b0;
        end else if (pending_words.size() > 0) begin
          tx_word = pending_words.pop_front();
          in_ch.valid        <= 1'b1;
          in_ch.face_pick    <= tx_word.pick;
          in_ch.coord_a      <= tx_word.coord_a;
          in_ch.coord_b      <= tx_word.coord_b;
          in_ch.depth_jitter <= tx_word.jitter;
          tx_gap = draw_idle(send_idle);
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // output monitor with random stalls
  point_t want;
  int     rx_wait;
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
      rx_wait = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_points.size() == 0) begin
          report_mismatch($sformatf("unexpected point x=%0d y=%0d z=%0d bad=%0d",
                                    out_ch.pos_x, out_ch.pos_y, out_ch.pos_z,
                                    out_ch.bad_setup));
        end else begin
          want = expected_points.pop_front();
          if (out_ch.pos_x !== want.x)
            report_mismatch($sformatf("pos_x %0d, expected %0d", out_ch.pos_x, want.x));
          if (out_ch.pos_y !== want.y)
            report_mismatch($sformatf("pos_y %0d, expected %0d", out_ch.pos_y, want.y));
          if (out_ch.pos_z !== want.z)
            report_mismatch($sformatf("pos_z %0d, expected %0d", out_ch.pos_z, want.z));
          if (out_ch.bad_setup !== want.bad)
            report_mismatch($sformatf("bad_setup %0b, expected %0b", out_ch.bad_setup,
                                      want.bad));
        end
        n_checked++;
        rx_wait = draw_idle(recv_idle);
      end
      if (hold_rx) begin
        out_ch.ready <= 1'b0;
      end else if (rx_wait > 0) begin
        rx_wait--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // long receiver hold-off, once, so the pipeline fills and stalls the input
  initial begin
    hold_rx = 1'b0;
    wait (hold_go);
    @(posedge clk_i);
    hold_rx <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_rx <= 1'b0;
  end

  // run limit
  initial cycle_count = 0;
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[box_vertex_sampler] ERROR");
      $finish;
    end
  end

  // stimulus
  initial begin
    logic [LEN_BITS-1:0] reg_data;
    logic [1:0]          mode_val;
    int                  sel;
    int                  ph;
    int                  i;
    rst_ni = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_SAMPLE_MODE;
    cfg_ch.data = '0;
    in_ch.valid = 1'b0;
    in_ch.face_pick = '0;
    in_ch.coord_a = '0;
    in_ch.coord_b = '0;
    in_ch.depth_jitter = '0;
    out_ch.ready = 1'b0;
    box_mode = MODE_OFF;
    box_mask = FACE_MASK_RESET;
    box_size_x = '0;
    box_size_y = '0;
    box_size_z = '0;
    box_offset = '0;
    box_depth = '0;
    n_queued = 0;
    n_taken = 0;
    n_checked = 0;
    n_errors = 0;
    send_idle = 1;
    recv_idle = 1;
    hold_go = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // rejected mode after reset, then the spare code
    push_word('0, '0, '0, '0);
    push_word(FRAC_MAX, FRAC_MAX, FRAC_MAX, FRAC_MAX);
    drain();
    write_reg(REG_SAMPLE_MODE, LEN_BITS'(MODE_SPARE));
    push_word(FRAC_HALF, 16'h1234, 16'hedcb, FRAC_MAX);
    drain();

    // bulk at full size, no skin
    write_reg(REG_SIZE_X, LEN_MAX);
    write_reg(REG_SIZE_Y, LEN_MAX);
    write_reg(REG_SIZE_Z, LEN_MAX);
    write_reg(REG_SAMPLE_MODE, LEN_BITS'(MODE_VOLUME));
    push_word('0, '0, '0, '0);
    push_word(FRAC_MAX, FRAC_MAX, FRAC_MAX, FRAC_MAX);
    push_word(FRAC_HALF, FRAC_HALF, FRAC_HALF, FRAC_HALF);
    drain();

    // bulk with skin thicker than the x and y sides
    write_reg(REG_SIZE_X, 24'd100);
    write_reg(REG_SIZE_Y, '0);
    write_reg(REG_SKIN_DEPTH, LEN_MAX);
    push_word('0, '0, FRAC_MAX, FRAC_HALF);
    push_word(FRAC_MAX, 16'h0001, '0, '0);
    drain();

    // surface with every face masked off
    write_reg(REG_SAMPLE_MODE, LEN_BITS'(MODE_FACES));
    write_reg(REG_FACE_MASK, '0);
    push_word(16'h4000, 16'h5555, 16'haaaa, 16'h0f0f);
    drain();

    // surface, all faces, no area anywhere: lands on the top z face
    write_reg(REG_FACE_MASK, LEN_BITS'(FACE_MASK_RESET));
    write_reg(REG_SIZE_X, '0);
    write_reg(REG_SIZE_Z, '0);
    push_word('0, FRAC_MAX, '0, FRAC_MAX);
    push_word(FRAC_MAX, '0, FRAC_MAX, '0);
    drain();

    // surface at full size with the widest offset and skin
    write_reg(REG_SIZE_X, LEN_MAX);
    write_reg(REG_SIZE_Y, LEN_MAX);
    write_reg(REG_SIZE_Z, LEN_MAX);
    write_reg(REG_SKIN_OFFSET, OFFSET_MAX);
    write_reg(REG_SKIN_DEPTH, LEN_MAX);
    push_word('0, '0, FRAC_MAX, FRAC_MAX);
    push_word(FRAC_MAX, FRAC_MAX, '0, '0);
    push_word(FRAC_HALF, 16'h7fff, 16'h8001, FRAC_HALF);
    push_word(16'h2aaa, 16'h3333, 16'hcccc, 16'h0001);
    drain();

    // most negative offset, zero skin so jitter drops out, x- and z+ only
    write_reg(REG_SKIN_OFFSET, OFFSET_MIN);
    write_reg(REG_SKIN_DEPTH, '0);
    write_reg(REG_FACE_MASK, LEN_BITS'(6'b100001));
    push_word('0, 16'h00ff, 16'hff00, FRAC_MAX);
    push_word(FRAC_MAX, 16'hff00, 16'h00ff, '0);
    drain();

    // random setups, each followed by a batch of random words
    for (ph = 0; ph < RANDOM_PHASES; ph++) begin
      sel = $urandom_range(0, 19);
      if (sel == 0) mode_val = MODE_OFF;
      else if (sel == 1) mode_val = MODE_SPARE;
      else if (sel < 9) mode_val = MODE_VOLUME;
      else mode_val = MODE_FACES;
      // unused upper bits sometimes set
      reg_data = LEN_BITS'($urandom);
      if ($urandom_range(0, 1) == 0) reg_data = '0;
      reg_data[1:0] = mode_val;
      write_reg(REG_SAMPLE_MODE, reg_data);

      reg_data = LEN_BITS'($urandom);
      if ($urandom_range(0, 1) == 0) reg_data[LEN_BITS-1:6] = '0;
      case ($urandom_range(0, 7))
        0: reg_data[5:0] = '0;
        1, 2: reg_data[5:0] = 6'b000001 << $urandom_range(0, 5);
        3: reg_data[5:0] = FACE_MASK_RESET;
        default: reg_data[5:0] = 6'($urandom_range(1, 63));
      endcase
      write_reg(REG_FACE_MASK, reg_data);

      write_reg(REG_SIZE_X, draw_length());
      write_reg(REG_SIZE_Y, draw_length());
      write_reg(REG_SIZE_Z, draw_length());
      reg_data = draw_length();
      if ($urandom_range(0, 1) == 0) reg_data = -reg_data;
      write_reg(REG_SKIN_OFFSET, reg_data);
      write_reg(REG_SKIN_DEPTH, ($urandom_range(0, 2) == 0) ? '0 : draw_length());

      send_idle = (ph == HOLD_PHASE) ? 0 : $urandom_range(0, 2);
      recv_idle = (ph == HOLD_PHASE) ? 0 : $urandom_range(0, 2);
      for (i = 0; i < PHASE_WORDS; i++)
        push_word(draw_fraction(), draw_fraction(), draw_fraction(), draw_fraction());
      if (ph == HOLD_PHASE) hold_go = 1'b1;
      drain();
    end

    if (n_errors == 0) begin
      $display("[box_vertex_sampler] OK");
    end else begin
      $display("[box_vertex_sampler] ERROR");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+hdl
hdl/bvs_pkg.sv
hdl/bvs_cfg_if.sv
hdl/bvs_in_if.sv
hdl/bvs_out_if.sv
hdl/bvs_pipe_ctrl.sv
hdl/bvs_face_pick.sv
hdl/box_vertex_sampler.sv
hdl/bvs_checker.sv
bench/tb_box_vertex_sampler.sv
